// ===== rtl/core/rne_pkg.sv =====
package rne_pkg;

    // Defaults for the top-level parameters.
    localparam int VALUE_WIDTH_DEF = 16;

    // Configuration register.
    localparam int          MAX_LEN_W     = 6;
    localparam logic [5:0]  MAX_LEN_RESET = 6'd63;

    // Microprogram geometry.
    localparam int UPC_W    = 4;
    localparam int WEIGHT_W = 10;

    // ASCII numeral characters.
    localparam logic [7:0] CH_NONE = 8'h00;
    localparam logic [7:0] CH_I    = 8'h49;
    localparam logic [7:0] CH_V    = 8'h56;
    localparam logic [7:0] CH_X    = 8'h58;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_M    = 8'h4D;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // One control word: the weight to test and subtract, the characters it
    // produces, and the step to jump to when the weight no longer fits.
    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [7:0]          first;
        logic [7:0]          second;
        logic [UPC_W-1:0]    jump;
    } t_uword;

    function automatic t_uword uc_rom(input logic [UPC_W-1:0] upc);
        t_uword w;
        case (upc)
            4'd0:    w = '{weight: 10'd1000, first: CH_M, second: CH_NONE, jump: 4'd1};
            4'd1:    w = '{weight: 10'd900,  first: CH_C, second: CH_M,    jump: 4'd2};
            4'd2:    w = '{weight: 10'd500,  first: CH_D, second: CH_NONE, jump: 4'd3};
            4'd3:    w = '{weight: 10'd400,  first: CH_C, second: CH_D,    jump: 4'd4};
            4'd4:    w = '{weight: 10'd100,  first: CH_C, second: CH_NONE, jump: 4'd5};
            4'd5:    w = '{weight: 10'd90,   first: CH_X, second: CH_C,    jump: 4'd6};
            4'd6:    w = '{weight: 10'd50,   first: CH_L, second: CH_NONE, jump: 4'd7};
            4'd7:    w = '{weight: 10'd40,   first: CH_X, second: CH_L,    jump: 4'd8};
            4'd8:    w = '{weight: 10'd10,   first: CH_X, second: CH_NONE, jump: 4'd9};
            4'd9:    w = '{weight: 10'd9,    first: CH_I, second: CH_X,    jump: 4'd10};
            4'd10:   w = '{weight: 10'd5,    first: CH_V, second: CH_NONE, jump: 4'd11};
            4'd11:   w = '{weight: 10'd4,    first: CH_I, second: CH_V,    jump: 4'd12};
            4'd12:   w = '{weight: 10'd1,    first: CH_I, second: CH_NONE, jump: 4'd12};
            default: w = '{weight: 10'd1,    first: CH_I, second: CH_NONE, jump: 4'd12};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/roman_numeral_encoder.sv =====
// Roman numeral encoder.
//
// Input channel (s_axis_*): one transaction carries one unsigned value in
// tdata. Only the low VALUE_WIDTH bits are converted.
// Output channel (m_axis_*): one transaction per numeral character, most
// significant first. tdata holds the ASCII character, tuser flags an error
// result (symbol zero) and tlast marks the final transaction of a value.
// A zero value gives a single error result. When the numeral would grow past
// max_length characters, output stops after max_length characters with one
// error result. Configuration: i_cfg_we writes i_cfg_wdata into max_length.
//
// Sequencing: the value is taken while idle; then each character costs one
// sequencer step, and each table step that is passed over costs one more
// step (at most twelve per value). The rate is set by the microcoded
// sequencer, which retires one control word per cycle while the output
// is not stalled. The output register holds one character; the sequencer
// advances in the cycle the receiver takes it, so a stalled receiver
// freezes the sequencer with nothing lost. Reset clears the sequencer to
// idle and max_length to 63.
module roman_numeral_encoder
    import rne_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [MAX_LEN_W-1:0]                 i_cfg_wdata,    // max_length
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((VALUE_WIDTH + 7) / 8)*8-1:0] s_axis_tdata,   // [VALUE_WIDTH-1:0] value
    // output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [7:0]                           m_axis_tdata,   // [7:0] symbol
    output logic                                 m_axis_tuser,   // [0] error
    output logic                                 m_axis_tlast
);

    t_state                 r_state, n_state;
    logic [MAX_LEN_W-1:0]   r_max_len;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [7:0]             r_pend;
    logic [MAX_LEN_W-1:0]   r_count;
    logic [UPC_W-1:0]       r_upc;

    logic                   r_out_valid;
    logic [7:0]             r_out_sym;
    logic                   r_out_err;
    logic                   r_out_last;

    logic                   in_go;
    logic                   run;
    logic                   step_go;
    t_uword                 uw;
    logic [VALUE_WIDTH:0]   diff;
    logic                   take;
    logic                   is_err;
    logic                   pend_last;
    logic                   take_last;
    logic                   finish;
    logic                   emit;

    // Sequencer control: ready only while idle.
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        run           = (r_state == ST_RUN);
    end

    assign in_go   = s_axis_tvalid && s_axis_tready;
    // Advance only when the output register is free or being drained.
    assign step_go = run && (!r_out_valid || m_axis_tready);

    // Fetch the control word and test its weight with one subtract.
    assign uw   = uc_rom(r_upc);
    assign diff = {1'b0, r_rem} - (VALUE_WIDTH + 1)'(uw.weight);
    assign take = !diff[VALUE_WIDTH];

    // Nothing left to encode while running only happens for a zero value.
    assign is_err    = ((r_rem == '0) && (r_pend == CH_NONE)) || (r_count >= r_max_len);
    assign pend_last = (r_rem == '0);
    assign take_last = (diff[VALUE_WIDTH-1:0] == '0) && (uw.second == CH_NONE);
    assign emit      = is_err || (r_pend != CH_NONE) || take;
    assign finish    = is_err || ((r_pend != CH_NONE) ? pend_last : (take && take_last));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_go) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step_go && finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_max_len <= MAX_LEN_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= CH_NONE;
        end else if (in_go) begin
            r_rem   <= s_axis_tdata[VALUE_WIDTH-1:0];
            r_pend  <= CH_NONE;
            r_count <= '0;
            r_upc   <= '0;
        end else if (step_go) begin
            if (is_err) begin
                // drop any half-sent pair
                r_pend <= CH_NONE;
            end else if (r_pend != CH_NONE) begin
                r_pend  <= CH_NONE;
                r_count <= r_count + 1'b1;
            end else if (take) begin
                // hold the step: the same weight may fit again
                r_rem   <= diff[VALUE_WIDTH-1:0];
                r_pend  <= uw.second;
                r_count <= r_count + 1'b1;
            end else begin
                r_upc <= uw.jump;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_go && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go && emit) begin
            if (is_err) begin
                r_out_sym  <= CH_NONE;
                r_out_err  <= 1'b1;
                r_out_last <= 1'b1;
            end else if (r_pend != CH_NONE) begin
                r_out_sym  <= r_pend;
                r_out_err  <= 1'b0;
                r_out_last <= pend_last;
            end else begin
                r_out_sym  <= uw.first;
                r_out_err  <= 1'b0;
                r_out_last <= take_last;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sym;
    assign m_axis_tuser  = r_out_err;
    assign m_axis_tlast  = r_out_last;

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == CH_NONE)))
        else $error("error result without last or with a symbol");

    a_pend_only_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != CH_NONE) |-> (r_state == ST_RUN))
        else $error("pending pair character while idle");

    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == ST_RUN))
        else $error("accepted value did not start the sequencer");

    a_finish_emits_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_go && finish) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("sequencer went idle without a last result");

endmodule
